@@ rtl/hsd_pkg.sv @@
package hsd_pkg;

	localparam int NODE_DEPTH = 511;
	localparam int NODE_AW    = 9;
	localparam int LINK_W     = 27;
	localparam int NWT_W      = 40;
	localparam int NODE_W     = LINK_W + NWT_W;
	localparam int SYM_DEPTH  = 256;
	localparam int SYM_AW     = 8;
	localparam int WT_W       = 32;
	localparam int LEAF_BIT   = 26;

	typedef enum logic [5:0] {
		PH_COUNT  = 6'b000001,
		PH_SYM    = 6'b000010,
		PH_WEIGHT = 6'b000100,
		PH_PAD    = 6'b001000,
		PH_LEN    = 6'b010000,
		PH_BODY   = 6'b100000
	} phase_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_LEAF   = 11'b00000000010,
		ST_MCHK   = 11'b00000000100,
		ST_SCAN   = 11'b00000001000,
		ST_MERGE  = 11'b00000010000,
		ST_KILLA  = 11'b00000100000,
		ST_KILLB  = 11'b00001000000,
		ST_ROOT   = 11'b00010000000,
		ST_ROOTD  = 11'b00100000000,
		ST_BIT_RD = 11'b01000000000,
		ST_BIT_EV = 11'b10000000000
	} state_t;

	// Request from the tree walker to the output stage
	typedef struct packed {
		logic       push;
		logic       flush;
		logic [7:0] sym;
	} emit_t;

endpackage

@@ rtl/hsd_ram.sv @@
module hsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port that holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/hsd_out_stage.sv @@
module hsd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  hsd_pkg::emit_t emit,
	output logic          room,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,  // decoded_byte
	output logic          m_tlast   // last_of_run
);
	import hsd_pkg::*;

	logic       pend_v_q;
	logic [7:0] pend_q;
	logic       out_v_q;
	logic [7:0] out_q;
	logic       last_q;

	// One symbol waits in the pending slot until its successor or the byte end shows its tlast
	assign room = !pend_v_q || !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (emit.push && room) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
					out_q   <= pend_q;
					last_q  <= 1'b0;
				end
				pend_q   <= emit.sym;
				pend_v_q <= 1'b1;
			end else if (emit.flush && room && pend_v_q) begin
				out_v_q  <= 1'b1;
				out_q    <= pend_q;
				last_q   <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign m_tlast  = last_q;

endmodule

@@ rtl/huffman_stream_decoder_core.sv @@
// Channel | Dir | tdata            | tlast
// s_*     | in  | [7:0] stream byte| end of stream
// m_*     | out | [7:0] symbol     | last symbol of the input byte
//
// Header bytes are taken while idle. After the length field the tree is built
// in memory: a leaf sweep over all 256 symbols, then per merge a check, a scan
// over all nodes and writes of the merged node and the live flags (ST_MERGE,
// ST_KILLA, ST_KILLB), then a final check and a fetch of the root. Each body
// byte is accepted, then each decoded bit takes a node memory read (ST_BIT_RD)
// and an evaluation (ST_BIT_EV), no read for a single-leaf tree, and a flush
// ends the byte. Output stalls hold the walk; reset clears all control state.
module huffman_stream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // stream_byte
	input  logic       s_tlast,   // end_of_stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // decoded_byte
	output logic       m_tlast    // last_of_run
);
	import hsd_pkg::*;

	state_t              state_q;
	phase_t              phase_q;
	logic [2:0]          fidx_q;
	logic [15:0]         entry_q;
	logic [15:0]         seen_q;
	logic [7:0]          psym_q;
	logic [31:0]         asm_q;
	logic [7:0]          pad_q;
	logic [34:0]         bits_q;
	logic [SYM_DEPTH-1:0] present_q;
	logic [9:0]          ntot_q;
	logic [8:0]          live_q;
	logic [8:0]          sweep_q;
	logic                v_s1;
	logic [7:0]          sym_s1;
	logic [9:0]          scan_q;
	logic                m1v_q, m2v_q;
	logic [NWT_W-1:0]    m1w_q, m2w_q;
	logic [NODE_AW-1:0]  m1i_q, m2i_q;
	logic [LINK_W-1:0]   rootl_q;
	logic [LINK_W-1:0]   cur_q;
	logic [7:0]          sh_q;
	logic [3:0]          cnt_q;
	logic                eos_q;

	logic                wt_we, wt_re;
	logic [SYM_AW-1:0]   wt_waddr, wt_raddr;
	logic [WT_W-1:0]     wt_wdata, wt_rdata;
	logic                nd_we, nd_re;
	logic [NODE_AW-1:0]  nd_waddr, nd_raddr;
	logic [NODE_W-1:0]   nd_wdata, nd_rdata;
	logic                lv_we, lv_re;
	logic [NODE_AW-1:0]  lv_waddr, lv_raddr;
	logic                lv_wdata, lv_rdata;

	emit_t               emit;
	logic                room;

	logic [31:0]         asm_n;
	logic [15:0]         cnt16_n;
	logic [15:0]         seen_n;
	logic [34:0]         total;
	logic [3:0]          nb;
	logic [NODE_AW-1:0]  child;
	logic [LINK_W-1:0]   rd_links;
	logic [NWT_W-1:0]    rd_w;
	logic [NODE_AW-1:0]  root_n;
	logic                accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign asm_n    = {asm_q[23:0], s_tdata};
	assign cnt16_n  = {entry_q[7:0], s_tdata};
	assign seen_n   = seen_q + 16'd1;
	assign total    = {asm_n, 3'b000};
	assign nb       = (bits_q < 35'd8) ? bits_q[3:0] : 4'd8;
	assign rd_links = nd_rdata[NODE_W-1:NWT_W];
	assign rd_w     = nd_rdata[NWT_W-1:0];
	assign root_n   = (ntot_q == 10'd0) ? '0 : NODE_AW'(ntot_q - 10'd1);

	// Pick the child on the current bit, map the out-of-range index to node zero
	always_comb begin
		child = sh_q[7] ? cur_q[17:9] : cur_q[8:0];
		if (child == NODE_AW'(NODE_DEPTH)) begin
			child = '0;
		end
	end

	// Drive the memory ports and the output requests per state
	always_comb begin
		wt_we    = 1'b0;
		wt_waddr = psym_q;
		wt_wdata = asm_n;
		wt_re    = 1'b0;
		wt_raddr = sweep_q[7:0];
		nd_we    = 1'b0;
		nd_waddr = ntot_q[8:0];
		nd_wdata = {1'b1, sym_s1, 18'd0, 8'd0, wt_rdata};
		nd_re    = 1'b0;
		nd_raddr = scan_q[8:0];
		lv_we    = 1'b0;
		lv_waddr = ntot_q[8:0];
		lv_wdata = 1'b1;
		lv_re    = 1'b0;
		lv_raddr = scan_q[8:0];
		emit     = '0;
		unique case (state_q)
			ST_IDLE: begin
				wt_we = accept && (phase_q == PH_WEIGHT) && (fidx_q == 3'd3);
			end
			ST_LEAF: begin
				wt_re = !sweep_q[8];
				nd_we = v_s1;
				lv_we = v_s1;
			end
			ST_SCAN: begin
				nd_re = (scan_q < ntot_q);
				lv_re = (scan_q < ntot_q);
			end
			ST_MERGE: begin
				nd_we    = 1'b1;
				nd_wdata = {1'b0, 8'd0, m2i_q, m1i_q, m1w_q + m2w_q};
				lv_we    = 1'b1;
			end
			ST_KILLA: begin
				lv_we    = 1'b1;
				lv_waddr = m1i_q;
				lv_wdata = 1'b0;
			end
			ST_KILLB: begin
				lv_we    = 1'b1;
				lv_waddr = m2i_q;
				lv_wdata = 1'b0;
			end
			ST_ROOT: begin
				nd_re    = 1'b1;
				nd_raddr = root_n;
			end
			ST_BIT_RD: begin
				if (cnt_q == 4'd0) begin
					emit.flush = 1'b1;
				end else if (ntot_q == 10'd1) begin
					emit.push = 1'b1;
					emit.sym  = rootl_q[25:18];
				end else begin
					nd_re    = 1'b1;
					nd_raddr = child;
				end
			end
			ST_BIT_EV: begin
				emit.push = rd_links[LEAF_BIT];
				emit.sym  = rd_links[25:18];
			end
			default: begin
			end
		endcase
	end

	// Parse the header, build the tree, walk the body bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_COUNT;
			fidx_q    <= '0;
			entry_q   <= '0;
			seen_q    <= '0;
			psym_q    <= '0;
			asm_q     <= '0;
			pad_q     <= '0;
			bits_q    <= '0;
			present_q <= '0;
			ntot_q    <= '0;
			live_q    <= '0;
			sweep_q   <= '0;
			v_s1      <= 1'b0;
			scan_q    <= '0;
			m1v_q     <= 1'b0;
			m2v_q     <= 1'b0;
			cnt_q     <= '0;
			eos_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (phase_q)
							PH_COUNT: begin
								entry_q <= cnt16_n;
								if (fidx_q == 3'd0) begin
									fidx_q <= 3'd1;
								end else begin
									fidx_q  <= '0;
									seen_q  <= '0;
									phase_q <= (cnt16_n != 16'd0) ? PH_SYM : PH_PAD;
								end
							end
							PH_SYM: begin
								psym_q  <= s_tdata;
								asm_q   <= '0;
								fidx_q  <= '0;
								phase_q <= PH_WEIGHT;
							end
							PH_WEIGHT: begin
								asm_q <= asm_n;
								if (fidx_q < 3'd3) begin
									fidx_q <= fidx_q + 3'd1;
								end else begin
									fidx_q            <= '0;
									present_q[psym_q] <= 1'b1;
									seen_q            <= seen_n;
									phase_q <= (seen_n == entry_q) ? PH_PAD : PH_SYM;
								end
							end
							PH_PAD: begin
								pad_q   <= s_tdata;
								asm_q   <= '0;
								fidx_q  <= '0;
								phase_q <= PH_LEN;
							end
							PH_LEN: begin
								asm_q <= asm_n;
								if (fidx_q < 3'd3) begin
									fidx_q <= fidx_q + 3'd1;
								end else begin
									fidx_q  <= '0;
									bits_q  <= (total > 35'(pad_q)) ? total - 35'(pad_q) : '0;
									phase_q <= PH_BODY;
									ntot_q  <= '0;
									live_q  <= '0;
									sweep_q <= '0;
									v_s1    <= 1'b0;
									state_q <= ST_LEAF;
								end
							end
							PH_BODY: begin
								bits_q <= bits_q - 35'(nb);
								sh_q   <= s_tdata;
								cnt_q  <= nb;
								eos_q  <= s_tlast;
								if (nb != 4'd0 && ntot_q != 10'd0) begin
									state_q <= ST_BIT_RD;
								end
							end
							default: begin
								phase_q <= PH_COUNT;
							end
						endcase
						// Drop the stream state after the final byte unless a walk is pending
						if (s_tlast && !(phase_q == PH_BODY && nb != 4'd0 && ntot_q != 10'd0)) begin
							state_q   <= ST_IDLE;
							phase_q   <= PH_COUNT;
							fidx_q    <= '0;
							entry_q   <= '0;
							seen_q    <= '0;
							psym_q    <= '0;
							asm_q     <= '0;
							pad_q     <= '0;
							bits_q    <= '0;
							present_q <= '0;
							ntot_q    <= '0;
						end
					end
				end
				ST_LEAF: begin
					if (v_s1) begin
						ntot_q <= ntot_q + 10'd1;
						live_q <= live_q + 9'd1;
					end
					if (sweep_q[8]) begin
						v_s1    <= 1'b0;
						state_q <= ST_MCHK;
					end else begin
						v_s1    <= present_q[sweep_q[7:0]];
						sym_s1  <= sweep_q[7:0];
						sweep_q <= sweep_q + 9'd1;
					end
				end
				ST_MCHK: begin
					if (live_q > 9'd1) begin
						scan_q  <= '0;
						v_s1    <= 1'b0;
						m1v_q   <= 1'b0;
						m2v_q   <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_SCAN: begin
					// Keep the two least live nodes, earlier index wins a tie
					if (v_s1 && lv_rdata) begin
						if (!m1v_q || rd_w < m1w_q) begin
							m2v_q <= m1v_q;
							m2w_q <= m1w_q;
							m2i_q <= m1i_q;
							m1v_q <= 1'b1;
							m1w_q <= rd_w;
							m1i_q <= scan_q[8:0] - 9'd1;
						end else if (!m2v_q || rd_w < m2w_q) begin
							m2v_q <= 1'b1;
							m2w_q <= rd_w;
							m2i_q <= scan_q[8:0] - 9'd1;
						end
					end
					if (scan_q < ntot_q) begin
						v_s1   <= 1'b1;
						scan_q <= scan_q + 10'd1;
					end else begin
						v_s1    <= 1'b0;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					ntot_q  <= ntot_q + 10'd1;
					state_q <= ST_KILLA;
				end
				ST_KILLA: begin
					state_q <= ST_KILLB;
				end
				ST_KILLB: begin
					live_q  <= live_q - 9'd1;
					state_q <= ST_MCHK;
				end
				ST_ROOT: begin
					state_q <= ST_ROOTD;
				end
				ST_ROOTD: begin
					rootl_q <= rd_links;
					cur_q   <= rd_links;
					state_q <= ST_IDLE;
				end
				ST_BIT_RD: begin
					if (cnt_q == 4'd0) begin
						// Flush the held symbol as the last of this byte
						if (room) begin
							state_q <= ST_IDLE;
							if (eos_q) begin
								phase_q   <= PH_COUNT;
								fidx_q    <= '0;
								entry_q   <= '0;
								seen_q    <= '0;
								psym_q    <= '0;
								asm_q     <= '0;
								pad_q     <= '0;
								bits_q    <= '0;
								present_q <= '0;
								ntot_q    <= '0;
							end
						end
					end else if (ntot_q == 10'd1) begin
						if (room) begin
							sh_q  <= {sh_q[6:0], 1'b0};
							cnt_q <= cnt_q - 4'd1;
						end
					end else begin
						state_q <= ST_BIT_EV;
					end
				end
				ST_BIT_EV: begin
					if (!rd_links[LEAF_BIT] || room) begin
						cur_q   <= rd_links[LEAF_BIT] ? rootl_q : rd_links;
						sh_q    <= {sh_q[6:0], 1'b0};
						cnt_q   <= cnt_q - 4'd1;
						state_q <= ST_BIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	hsd_ram #(.WIDTH(WT_W), .DEPTH(SYM_DEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (wt_wdata),
		.re    (wt_re),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	hsd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.re    (nd_re),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	hsd_ram #(.WIDTH(1), .DEPTH(NODE_DEPTH)) u_live_ram (
		.clk   (clk),
		.we    (lv_we),
		.waddr (lv_waddr),
		.wdata (lv_wdata),
		.re    (lv_re),
		.raddr (lv_raddr),
		.rdata (lv_rdata)
	);

	hsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/hsd_checker.sv @@
module hsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic       m_tlast
);

	// Hold a stalled output transaction
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// A non-final symbol means its byte is still in work
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while a run is open");

	// Leave idle only on an accepted transaction
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready fell without an input transaction");

endmodule

bind huffman_stream_decoder_core hsd_checker u_hsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tlast  (m_tlast)
);

@@ tb/tb_huffman_stream_decoder_core.sv @@
module tb_huffman_stream_decoder_core;
	import hsd_pkg::*;

	localparam int IDLE_LIMIT = 400000;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} stream_item_t;

	typedef struct {
		logic [7:0] sym;
		logic       last;
	} symbol_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	stream_item_t pending_bytes[$];
	symbol_t      expected_syms[$];
	int           error_count = 0;
	int           quiet_cycles = 0;
	int           send_idle = 0;
	int           recv_idle = 0;

	// decoder shadow state
	phase_t      dec_phase = PH_COUNT;
	int          dec_fidx = 0;
	logic [15:0] dec_entry_total = 0;
	logic [15:0] dec_entries_seen = 0;
	logic [7:0]  dec_pend_sym = 0;
	logic [31:0] dec_word = 0;
	logic [31:0] dec_weights[256];
	logic        dec_present[256];
	logic [7:0]  dec_pad = 0;
	longint      dec_bits_left = 0;
	logic [26:0] dec_links[NODE_DEPTH];
	logic [39:0] dec_nwt[NODE_DEPTH];
	logic        dec_live[NODE_DEPTH];
	int          dec_node_total = 0;
	int          dec_root = 0;
	int          dec_walk = 0;

	huffman_stream_decoder_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// clear per-stream state
	task automatic clear_stream();
		dec_phase = PH_COUNT;
		dec_fidx = 0;
		dec_entry_total = 0;
		dec_entries_seen = 0;
		dec_pend_sym = 0;
		dec_word = 0;
		dec_pad = 0;
		dec_bits_left = 0;
		for (int i = 0; i < 256; i++) dec_present[i] = 1'b0;
		for (int i = 0; i < NODE_DEPTH; i++) dec_live[i] = 1'b0;
		dec_node_total = 0;
		dec_root = 0;
		dec_walk = 0;
	endtask

	// least live node by (weight, index), excluding skip
	function automatic int least_node(int skip);
		int best;
		best = NODE_DEPTH;
		for (int i = 0; i < dec_node_total; i++) begin
			if (dec_live[i] && i != skip)
				if (best == NODE_DEPTH || dec_nwt[i] < dec_nwt[best]) best = i;
		end
		return best;
	endfunction

	task automatic build_tree();
		int live;
		int a;
		int b;
		live = 0;
		for (int i = 0; i < NODE_DEPTH; i++) dec_live[i] = 1'b0;
		dec_node_total = 0;
		for (int s = 0; s < 256; s++) begin
			if (dec_present[s]) begin
				dec_links[dec_node_total] = (27'd1 << LEAF_BIT) | (27'(s) << 18);
				dec_nwt[dec_node_total] = 40'(dec_weights[s]);
				dec_live[dec_node_total] = 1'b1;
				dec_node_total++;
				live++;
			end
		end
		while (live > 1 && dec_node_total < NODE_DEPTH) begin
			a = least_node(NODE_DEPTH);
			b = least_node(a);
			dec_links[dec_node_total] = (27'(b) << 9) | 27'(a);
			dec_nwt[dec_node_total] = dec_nwt[a] + dec_nwt[b];
			dec_live[dec_node_total] = 1'b1;
			dec_live[a] = 1'b0;
			dec_live[b] = 1'b0;
			dec_node_total++;
			live--;
		end
		dec_root = dec_node_total > 0 ? dec_node_total - 1 : 0;
		dec_walk = dec_root;
	endtask

	// advance the shadow decoder by one accepted stream byte
	task automatic decode_byte(logic [7:0] b, logic eos);
		symbol_t run[$];
		symbol_t r;
		int nb;
		int nxt;
		logic [26:0] lk;
		case (dec_phase)
			PH_COUNT: begin
				dec_entry_total = {dec_entry_total[7:0], b};
				if (dec_fidx == 0) dec_fidx = 1;
				else begin
					dec_fidx = 0;
					dec_entries_seen = 0;
					dec_phase = dec_entry_total != 0 ? PH_SYM : PH_PAD;
				end
			end
			PH_SYM: begin
				dec_pend_sym = b;
				dec_word = 0;
				dec_fidx = 0;
				dec_phase = PH_WEIGHT;
			end
			PH_WEIGHT: begin
				dec_word = {dec_word[23:0], b};
				if (dec_fidx < 3) dec_fidx++;
				else begin
					dec_fidx = 0;
					dec_weights[dec_pend_sym] = dec_word;
					dec_present[dec_pend_sym] = 1'b1;
					dec_entries_seen = dec_entries_seen + 16'd1;
					dec_phase = dec_entries_seen == dec_entry_total ? PH_PAD : PH_SYM;
				end
			end
			PH_PAD: begin
				dec_pad = b;
				dec_word = 0;
				dec_fidx = 0;
				dec_phase = PH_LEN;
			end
			PH_LEN: begin
				dec_word = {dec_word[23:0], b};
				if (dec_fidx < 3) dec_fidx++;
				else begin
					dec_fidx = 0;
					dec_bits_left = longint'(dec_word) * 8;
					dec_bits_left = dec_bits_left > dec_pad ? dec_bits_left - dec_pad : 0;
					build_tree();
					dec_phase = PH_BODY;
				end
			end
			default: begin
				nb = dec_bits_left < 8 ? int'(dec_bits_left) : 8;
				for (int k = 0; k < nb; k++) begin
					dec_bits_left--;
					if (dec_node_total == 1) begin
						r.sym = dec_links[0][25:18];
						r.last = 1'b0;
						run.push_back(r);
					end else if (dec_node_total > 1) begin
						lk = dec_links[dec_walk];
						nxt = b[7-k] ? int'(lk[17:9]) : int'(lk[8:0]);
						if (nxt >= NODE_DEPTH) nxt = 0;
						if (dec_links[nxt][LEAF_BIT]) begin
							r.sym = dec_links[nxt][25:18];
							r.last = 1'b0;
							run.push_back(r);
							dec_walk = dec_root;
						end else begin
							dec_walk = nxt;
						end
					end
				end
			end
		endcase
		if (run.size() > 0) run[run.size()-1].last = 1'b1;
		foreach (run[i]) expected_syms.push_back(run[i]);
		if (eos) clear_stream();
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drive the stream input from the pending queue
	always @(posedge clk) begin
		logic took;
		took = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(pending_bytes.pop_front());
				send_idle = pick_gap();
				took = 1'b1;
			end
			if (s_tvalid && !s_tready) begin
				// hold the current transaction
			end else if (send_idle > 0) begin
				send_idle--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0 &&
					!(pending_bytes[0].drain && (took || expected_syms.size() != 0))) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bytes[0].data;
				s_tlast <= pending_bytes[0].last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predict on input transactions, check output transactions, pace ready
	always @(posedge clk) begin
		symbol_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (s_tvalid && s_tready) begin
				quiet_cycles = 0;
				decode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				if (expected_syms.size() == 0) begin
					$display("%0t: unexpected symbol %h last %b", $time, m_tdata, m_tlast);
					error_count++;
				end else begin
					want = expected_syms.pop_front();
					if (m_tdata !== want.sym) begin
						$display("%0t: symbol expected %h actual %h", $time, want.sym, m_tdata);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
						error_count++;
					end
				end
				recv_idle = pick_gap();
			end
			if (recv_idle > 0) begin
				recv_idle--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAIL huffman_stream_decoder_core");
				$finish;
			end
		end
	end

	task automatic push_byte(logic [7:0] d, logic l, logic dr = 1'b0);
		stream_item_t it;
		it.data = d;
		it.last = l;
		it.drain = dr;
		pending_bytes.push_back(it);
	endtask

	task automatic push_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8], 1'b0);
	endtask

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom_range(1, 20);
			default: return $urandom;
		endcase
	endfunction

	// header with given symbols, then body bytes; end of stream on the last body byte
	task automatic push_stream(logic [7:0] syms[$], logic [7:0] pad, logic [31:0] len,
			int nbody, logic dr = 1'b0);
		push_byte(8'(syms.size() >> 8), 1'b0, dr);
		push_byte(8'(syms.size()), nbody == 0 && syms.size() == 0 && 1'b0);
		foreach (syms[i]) begin
			push_byte(syms[i], 1'b0);
			push_word(pick_weight());
		end
		push_byte(pad, 1'b0);
		push_word(len);
		for (int i = 0; i < nbody; i++) push_byte($urandom, i == nbody - 1);
	endtask

	initial begin
		logic [7:0] syms[$];
		int n;
		for (int i = 0; i < 256; i++) begin
			dec_weights[i] = 0;
			dec_present[i] = 1'b0;
		end
		clear_stream();

		// zero entry count: empty tree, nothing emitted
		syms = {};
		push_stream(syms, 8'd0, 32'd2, 2);
		// single leaf: one symbol per body bit, trailing byte ignored
		syms = {8'hFF};
		push_stream(syms, 8'd3, 32'd2, 3);
		// padding exceeds body bits
		syms = {8'h00, 8'h80};
		push_stream(syms, 8'hFF, 32'd1, 1);
		// end of stream inside the header
		push_byte(8'h00, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'h41, 1'b1);
		// repeated symbol overwrites its weight, waits for an empty pipe
		syms = {8'h05, 8'h7F, 8'h05};
		push_stream(syms, 8'd0, 32'hFFFF_FFFF, 4, 1'b1);

		// random streams
		for (int s = 0; s < 3; s++) begin
			syms = {};
			n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 8);
			for (int i = 0; i < n; i++) syms.push_back($urandom);
			if ($urandom_range(0, 5) == 0) begin
				// noise with an early end of stream
				for (int i = 0; i < $urandom_range(1, 12); i++) push_byte($urandom, 1'b0);
				push_byte($urandom, 1'b1);
			end else begin
				push_stream(syms, $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom),
					$urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(1, 10)),
					$urandom_range(1, 10), $urandom_range(0, 7) == 0);
			end
		end
		// a wider alphabet in descending order
		syms = {};
		for (int i = 0; i < 16; i++) syms.push_back(8'(255 - i));
		push_stream(syms, 8'd5, 32'd8, 8, 1'b1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_syms.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_syms.size() == 0) begin
			$display("PASS huffman_stream_decoder_core");
		end else begin
			$display("FAIL huffman_stream_decoder_core");
		end
		$finish;
	end

endmodule
